[rtl/gamma_colour_map_entry_defines.svh]
// ----------------------------------------------------------------------------
// Gamma colour map entry: assertion macros
// Shared property shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GAMMA_COLOUR_MAP_ENTRY_DEFINES_SVH
`define GAMMA_COLOUR_MAP_ENTRY_DEFINES_SVH

// Same-cycle implication
`define GCME_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GCME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gcme_pkg.sv]
// ----------------------------------------------------------------------------
// Gamma colour map entry package
// Shared widths, latencies, codes and the square root step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcme_pkg;

    localparam int MAX_DEPTH_DEF = 1024;
    localparam int X_W           = 11;   // log operand width
    localparam int Q_W           = 4;    // integer part of a log
    localparam int FRAC_W        = 30;   // log and exponent fraction bits
    localparam int LOG_W         = Q_W + FRAC_W;
    localparam int Y_W           = 33;   // Q.32 value up to 1.0
    localparam int LOG_LAT       = FRAC_W;
    localparam int SQ_STEPS      = 4;    // root bits resolved per stage
    localparam int SQ_SUBS       = 32 / SQ_STEPS;
    localparam int EXP_LAT       = FRAC_W * SQ_SUBS;
    localparam int K_W           = 5;

    localparam logic [15:0] MIN_GAMMA   = 16'd5;
    localparam logic [15:0] GAMMA_RST   = 16'd4096;
    localparam logic [10:0] DEPTH_RST   = 11'd256;

    typedef enum logic [2:0] {
        REG_GAMMA = 3'd0,
        REG_DEPTH = 3'd1,
        REG_RED   = 3'd2,
        REG_GREEN = 3'd3,
        REG_BLUE  = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_INDEX  = 2'd1,
        ST_OFFSET = 2'd2
    } status_t;

    // Restoring square root state: radicand bits left, remainder, root
    typedef struct packed {
        logic [63:0] rad;
        logic [35:0] rem;
        logic [31:0] root;
    } sq_t;

    // Sideband that travels with each word
    typedef struct packed {
        status_t             status;
        logic [2:0]          zero;
        logic [15:0]         gamma;
        logic [2:0][K_W-1:0] k;
    } side_t;

    // One root bit from the next two radicand bits
    function automatic sq_t sqrt_step(sq_t a);
        sq_t         r;
        logic [35:0] rem2;
        logic [35:0] trial;
        rem2  = {a.rem[33:0], a.rad[63:62]};
        trial = {2'b00, a.root, 2'b01};
        r.rad = {a.rad[61:0], 2'b00};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {a.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {a.root[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[rtl/gamma_colour_map_entry.sv]
// ----------------------------------------------------------------------------
// Gamma colour map entry
// Red, green and blue gamma levels for one colour map index.
// ----------------------------------------------------------------------------
// Takes one index per clock and returns its three levels through one input
// stage, 30 log2 squaring stages, one multiply stage, 240 square root stages
// of the 2^-f unit and one output register. The whole pipeline
// advances together and halts only while a result waits on out_ready.
// Write configuration only while no word is in flight.
`timescale 1ns / 1ps
`include "gamma_colour_map_entry_defines.svh"

module gamma_colour_map_entry #(
    parameter int MAX_DEPTH = gcme_pkg::MAX_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  entry_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] red_level,
    output logic [15:0] green_level,
    output logic [15:0] blue_level,
    output logic [1:0]  status
);

    localparam int LL  = gcme_pkg::LOG_LAT;
    localparam int EL  = gcme_pkg::EXP_LAT;
    localparam int SN  = LL + EL + 2;
    localparam int MI  = LL + 1;
    localparam int FW  = gcme_pkg::FRAC_W;
    localparam int LW  = gcme_pkg::LOG_W;
    localparam int KW  = gcme_pkg::K_W;
    localparam logic [16:0] MAXD = 17'(MAX_DEPTH);

    logic [15:0] gamma_reg;
    logic [10:0] depth_reg;
    logic [10:0] off_reg [3];

    logic             adv;
    logic             v_reg    [SN];
    gcme_pkg::side_t  side_reg [SN];
    logic [10:0]      n_reg    [3];
    logic [10:0]      d_reg;
    logic [FW-1:0]    pf_reg   [3];
    logic             out_valid_reg;
    logic [15:0]      lvl_reg  [3];
    gcme_pkg::status_t status_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg  <= gcme_pkg::GAMMA_RST;
            depth_reg  <= gcme_pkg::DEPTH_RST;
            off_reg[0] <= '0;
            off_reg[1] <= '0;
            off_reg[2] <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (gcme_pkg::cfg_reg_t'(cfg_idx))
                gcme_pkg::REG_GAMMA: gamma_reg  <= cfg_wdata;
                gcme_pkg::REG_DEPTH: depth_reg  <= cfg_wdata[10:0];
                gcme_pkg::REG_RED:   off_reg[0] <= cfg_wdata[10:0];
                gcme_pkg::REG_GREEN: off_reg[1] <= cfg_wdata[10:0];
                gcme_pkg::REG_BLUE:  off_reg[2] <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // Advance everything unless the output word is held
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Input stage: clamp, range checks, channel offsets
    logic [10:0]     depth_c;
    logic [10:0]     d_c;
    logic [10:0]     idx_c;
    logic [10:0]     n_c [3];
    gcme_pkg::side_t side_c;

    always_comb
    begin
        depth_c = ({6'b0, depth_reg} > MAXD) ? MAXD[10:0] : depth_reg;
        d_c     = (depth_c > 11'd1) ? depth_c - 11'd1 : 11'd1;
        idx_c   = {1'b0, entry_index};
        side_c.gamma = (gamma_reg < gcme_pkg::MIN_GAMMA) ? gcme_pkg::MIN_GAMMA : gamma_reg;
        side_c.k     = '0;
        priority if (off_reg[0] > depth_c || off_reg[1] > depth_c || off_reg[2] > depth_c)
        begin
            side_c.status = gcme_pkg::ST_OFFSET;
        end
        else if (idx_c >= depth_c)
        begin
            side_c.status = gcme_pkg::ST_INDEX;
        end
        else
        begin
            side_c.status = gcme_pkg::ST_OK;
        end
        for (int c = 0; c < 3; c++)
        begin
            n_c[c] = (idx_c > off_reg[c]) ? idx_c - off_reg[c] : 11'd0;
            side_c.zero[c] = (side_c.status != gcme_pkg::ST_OK) || (n_c[c] == 11'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_c;
            for (int c = 0; c < 3; c++)
            begin
                n_reg[c] <= n_c[c];
            end
        end
    end

    // Log2 lanes: three channels and the divisor
    logic [LW-1:0] ln [3];
    logic [LW-1:0] ld;

    gcme_log2 u_log_d (
        .clk  (clk),
        .en   (adv),
        .x    (d_reg),
        .logv (ld)
    );

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_log
            gcme_log2 u_log (
                .clk  (clk),
                .en   (adv),
                .x    (n_reg[c]),
                .logv (ln[c])
            );
        end
    endgenerate

    // Multiply stage: exponent = (log difference * gamma) >> 12
    gcme_pkg::side_t side_mul;
    logic [FW-1:0]   pf_c [3];

    always_comb
    begin
        logic [LW-1:0] e;
        logic [49:0]   prod;
        logic [7:0]    kf;
        side_mul = side_reg[MI-1];
        for (int i = 0; i < 3; i++)
        begin
            e    = (ld > ln[i]) ? ld - ln[i] : '0;
            prod = 50'(e) * 50'(side_reg[MI-1].gamma);
            kf   = prod[49:42];
            pf_c[i] = prod[41:12];
            side_mul.k[i] = kf[KW-1:0];
            if (kf >= 8'd17)
            begin
                side_mul.zero[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pf_reg[i] <= pf_c[i];
            end
        end
    end

    // Sideband travels beside the lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_c;
            for (int i = 1; i < SN; i++)
            begin
                if (i == MI)
                begin
                    side_reg[i] <= side_mul;
                end
                else
                begin
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SN; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < SN; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            out_valid_reg <= v_reg[SN-1];
        end
    end

    // 2^-frac lanes
    logic [gcme_pkg::Y_W-1:0] y [3];

    generate
        for (c = 0; c < 3; c++)
        begin : g_exp
            gcme_exp2 u_exp (
                .clk (clk),
                .en  (adv),
                .f   (pf_reg[c]),
                .y   (y[c])
            );
        end
    endgenerate

    // Round half up at the integer shift, saturate, zero when flagged
    logic [15:0] lvl_c [3];

    always_comb
    begin
        logic [33:0] sum;
        logic [33:0] sh;
        logic [KW-1:0] k;
        for (int i = 0; i < 3; i++)
        begin
            k   = side_reg[SN-1].k[i];
            sum = 34'(y[i]) + (34'd1 << (6'd15 + 6'(k)));
            sh  = sum >> (6'd16 + 6'(k));
            if (side_reg[SN-1].zero[i])
            begin
                lvl_c[i] = '0;
            end
            else if (sh > 34'd65535)
            begin
                lvl_c[i] = 16'hFFFF;
            end
            else
            begin
                lvl_c[i] = sh[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= side_reg[SN-1].status;
            for (int i = 0; i < 3; i++)
            begin
                lvl_reg[i] <= lvl_c[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_level   = lvl_reg[0];
    assign green_level = lvl_reg[1];
    assign blue_level  = lvl_reg[2];
    assign status      = status_reg;

    // Checks
    `GCME_ASSERT_IMP(a_err_zero, out_valid && status != gcme_pkg::ST_OK, red_level == 16'd0 && green_level == 16'd0 && blue_level == 16'd0, "error word carries nonzero level")
    `GCME_ASSERT_IMP(a_stall_src, !in_ready, out_valid && !out_ready, "stall without held output")
    `GCME_ASSERT_IMP(a_side_zero, v_reg[SN-1] && side_reg[SN-1].status != gcme_pkg::ST_OK, side_reg[SN-1].zero == 3'b111, "error word not flagged zero")

endmodule

[rtl/gcme_log2.sv]
// ----------------------------------------------------------------------------
// Gamma colour map entry: log2 pipeline
// Normalizes the operand and resolves one fraction bit per stage by squaring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcme_log2 (
    input  logic                          clk,
    input  logic                          en,
    input  logic [gcme_pkg::X_W-1:0]      x,
    output logic [gcme_pkg::LOG_W-1:0]    logv
);

    localparam int L  = gcme_pkg::LOG_LAT;
    localparam int FW = gcme_pkg::FRAC_W;
    localparam int QW = gcme_pkg::Q_W;

    logic [FW:0]   m_reg  [L];
    logic [FW-1:0] fr_reg [L];
    logic [QW-1:0] q_reg  [L];

    logic [QW-1:0] q_c;
    logic [FW:0]   m_c;

    // Find the leading one and align the mantissa to Q1.30
    always_comb
    begin
        q_c = '0;
        for (int b = 0; b < gcme_pkg::X_W; b++)
        begin
            if (x[b])
            begin
                q_c = QW'(b);
            end
        end
        m_c = (FW + 1)'(x) << (5'd30 - 5'(q_c));
    end

    genvar i;
    generate
        for (i = 0; i < L; i++)
        begin : g_stage
            logic [FW:0]     m_in;
            logic [FW-1:0]   fr_in;
            logic [QW-1:0]   q_in;
            logic [2*FW+1:0] sq;
            logic [FW+1:0]   t;
            logic [FW:0]     m_n;
            logic [FW-1:0]   fr_n;

            if (i == 0)
            begin : g_first
                assign m_in  = m_c;
                assign fr_in = '0;
                assign q_in  = q_c;
            end
            else
            begin : g_next
                assign m_in  = m_reg[i-1];
                assign fr_in = fr_reg[i-1];
                assign q_in  = q_reg[i-1];
            end

            // Square, then halve when the square reaches two
            always_comb
            begin
                sq   = m_in * m_in;
                t    = sq[2*FW+1:FW];
                fr_n = fr_in;
                if (t[FW+1])
                begin
                    m_n            = t[FW+1:1];
                    fr_n[FW-1-i]   = 1'b1;
                end
                else
                begin
                    m_n = t[FW:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[i]  <= m_n;
                    fr_reg[i] <= fr_n;
                    q_reg[i]  <= q_in;
                end
            end
        end
    endgenerate

    assign logv = {q_reg[L-1], fr_reg[L-1]};

endmodule

[rtl/gcme_exp2.sv]
// ----------------------------------------------------------------------------
// Gamma colour map entry: 2^-f pipeline
// Per fraction bit, from the lowest: halve if set, then take a square root
// over eight stages of four root bits each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcme_exp2 (
    input  logic                          clk,
    input  logic                          en,
    input  logic [gcme_pkg::FRAC_W-1:0]   f,
    output logic [gcme_pkg::Y_W-1:0]      y
);

    localparam int S  = gcme_pkg::EXP_LAT;
    localparam int FW = gcme_pkg::FRAC_W;
    localparam int YW = gcme_pkg::Y_W;
    localparam logic [YW-1:0] ONE = {1'b1, {(YW-1){1'b0}}};

    gcme_pkg::sq_t sq_reg   [S];
    logic          skip_reg [S];
    logic [FW-1:0] f_reg    [S];

    genvar s;
    generate
        for (s = 0; s < S; s++)
        begin : g_stage
            localparam int J   = s / gcme_pkg::SQ_SUBS;
            localparam int SUB = s % gcme_pkg::SQ_SUBS;

            gcme_pkg::sq_t a_in;
            gcme_pkg::sq_t a_out;
            logic          skip_n;
            logic [FW-1:0] f_n;

            if (SUB == 0)
            begin : g_head
                logic [YW-1:0] y_prev;
                logic [YW-1:0] y_h;

                if (s == 0)
                begin : g_first
                    assign y_prev = ONE;
                    assign f_n    = f;
                end
                else
                begin : g_mid
                    assign y_prev = skip_reg[s-1] ? ONE : {1'b0, sq_reg[s-1].root};
                    assign f_n    = f_reg[s-1];
                end
                // Halve on a set bit; full scale skips the root
                assign y_h       = f_n[J] ? (y_prev >> 1) : y_prev;
                assign skip_n    = y_h[YW-1];
                assign a_in.rad  = {y_h[YW-2:0], 32'b0};
                assign a_in.rem  = '0;
                assign a_in.root = '0;
            end
            else
            begin : g_body
                assign a_in   = sq_reg[s-1];
                assign skip_n = skip_reg[s-1];
                assign f_n    = f_reg[s-1];
            end

            // Resolve four root bits
            always_comb
            begin
                a_out = a_in;
                for (int b = 0; b < gcme_pkg::SQ_STEPS; b++)
                begin
                    a_out = gcme_pkg::sqrt_step(a_out);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_reg[s]   <= a_out;
                    skip_reg[s] <= skip_n;
                    f_reg[s]    <= f_n;
                end
            end
        end
    endgenerate

    assign y = skip_reg[S-1] ? ONE : {1'b0, sq_reg[S-1].root};

endmodule
